@@ rtl/rae_pkg.sv @@
// shared types and constants of the register alu execute unit
package rae_pkg;

    localparam int DATA_WIDTH = 64;
    localparam int REG_COUNT  = 16;
    localparam int IDX_W      = $clog2(REG_COUNT);
    localparam int CNT_W      = $clog2(DATA_WIDTH);
    localparam int FLAG_W     = 3;

    localparam logic [5:0]        SHIFT_IMM_MASK = 6'h3F;
    localparam logic [FLAG_W-1:0] FLAG_GREATER   = 3'b001;
    localparam logic [FLAG_W-1:0] FLAG_LESS      = 3'b010;
    localparam logic [FLAG_W-1:0] FLAG_EQUAL     = 3'b100;
    localparam logic [CNT_W-1:0]  CNT_LAST       = CNT_W'(DATA_WIDTH - 1);

    typedef enum logic [3:0] {
        ACT_MOV = 4'd0,
        ACT_OR  = 4'd1,
        ACT_AND = 4'd2,
        ACT_XOR = 4'd3,
        ACT_NOT = 4'd4,
        ACT_ADD = 4'd5,
        ACT_SUB = 4'd6,
        ACT_MUL = 4'd7,
        ACT_DIV = 4'd8,
        ACT_SHL = 4'd9,
        ACT_SHR = 4'd10,
        ACT_NEG = 4'd11,
        ACT_INC = 4'd12,
        ACT_DEC = 4'd13,
        ACT_CMP = 4'd14,
        ACT_NOP = 4'd15
    } action_t;

    typedef enum logic [1:0] {
        KIND_SIMPLE,
        KIND_LONG,
        KIND_CMP,
        KIND_NOP
    } kind_t;

    typedef struct packed {
        action_t               action;
        kind_t                 kind;
        logic [IDX_W-1:0]      dest_index;
        logic [IDX_W-1:0]      src_index;
        logic                  use_immediate;
        logic [DATA_WIDTH-1:0] immediate_value;
    } item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_ITER,
        ST_WRITE
    } back_state_t;

endpackage

@@ rtl/rae_ram.sv @@
// generic ram, one write port and two registered read ports
module rae_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

@@ rtl/rae_front.sv @@
// front stage: accepts items and classifies them
module rae_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [3:0]                   action,
    input  logic [rae_pkg::IDX_W-1:0]    dest_index,
    input  logic [rae_pkg::IDX_W-1:0]    src_index,
    input  logic                         use_immediate,
    input  logic [rae_pkg::DATA_WIDTH-1:0] immediate_value,
    input  logic                         q_full,
    output logic                         q_push,
    output rae_pkg::item_t               q_item
);
    import rae_pkg::*;

    logic  valid_reg, valid_next;
    item_t item_reg;
    kind_t kind;

    always_comb
    begin
        case (action_t'(action))
            ACT_MUL, ACT_DIV: kind = KIND_LONG;
            ACT_CMP:          kind = KIND_CMP;
            ACT_NOP:          kind = KIND_NOP;
            default:          kind = KIND_SIMPLE;
        endcase
    end

    assign in_stall = valid_reg && q_full;
    assign q_push   = valid_reg && !q_full;
    assign q_item   = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && !in_stall)
        begin
            valid_next = 1'b1;
        end
        else if (q_push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_reg.action          <= action_t'(action);
            item_reg.kind            <= kind;
            item_reg.dest_index      <= dest_index;
            item_reg.src_index       <= src_index;
            item_reg.use_immediate   <= use_immediate;
            item_reg.immediate_value <= immediate_value;
        end
    end

endmodule

@@ rtl/rae_queue.sv @@
// two-entry item queue between front and back
module rae_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  rae_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output rae_pkg::item_t head
);
    import rae_pkg::*;

    item_t      slot_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] count_reg, count_next;

    assign full  = count_reg == 2'd2;
    assign empty = count_reg == 2'd0;
    assign head  = slot_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = push ? ~wptr_reg : wptr_reg;
        rptr_next  = pop ? ~rptr_reg : rptr_reg;
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= push_item;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full || pop) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty) else $error("queue underflow");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 2'd1)
        else $error("queue count wrong");
`endif

endmodule

@@ rtl/rae_back.sv @@
// back stage: register file, alu, iterative multiply and divide, result register
module rae_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_empty,
    input  rae_pkg::item_t                 q_head,
    output logic                           q_pop,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [rae_pkg::DATA_WIDTH-1:0] dest_result,
    output logic [rae_pkg::FLAG_W-1:0]     compare_flags_out,
    output logic                           divide_by_zero
);
    import rae_pkg::*;

    localparam logic [DATA_WIDTH-1:0] ONES = '1;

    back_state_t           state_reg, state_next;
    item_t                 item_reg;
    logic [REG_COUNT-1:0]  vld_reg;
    logic [DATA_WIDTH-1:0] a_reg, a_next;
    logic [DATA_WIDTH-1:0] res_reg, res_next;
    logic                  wr_reg, wr_next;
    logic                  dz_reg, dz_next;
    logic [FLAG_W-1:0]     cmp_reg, cmp_next;
    logic [FLAG_W-1:0]     flags_reg;
    logic [DATA_WIDTH-1:0] acc_reg, acc_next;
    logic [DATA_WIDTH-1:0] x_reg, x_next;
    logic [DATA_WIDTH-1:0] y_reg, y_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  out_valid_reg;
    logic [DATA_WIDTH-1:0] out_res_reg;
    logic [FLAG_W-1:0]     out_flags_reg;
    logic                  out_dz_reg;

    logic [DATA_WIDTH-1:0] rdata_a, rdata_b, a, b, amt, simple;
    logic [DATA_WIDTH:0]   div_t;
    logic                  div_ge;
    logic [DATA_WIDTH-1:0] mul_acc, div_rem, div_q;
    logic                  ram_we, slot_free;

    rae_ram #(.WIDTH(DATA_WIDTH), .DEPTH(REG_COUNT)) u_rf (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (item_reg.dest_index),
        .wdata   (res_reg),
        .raddr_a (q_head.dest_index),
        .raddr_b (q_head.src_index),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    assign a   = vld_reg[item_reg.dest_index] ? rdata_a : '0;
    assign b   = item_reg.use_immediate ? item_reg.immediate_value
               : (vld_reg[item_reg.src_index] ? rdata_b : '0);
    assign amt = item_reg.use_immediate
               ? {{(DATA_WIDTH-6){1'b0}}, item_reg.immediate_value[5:0] & SHIFT_IMM_MASK}
               : b;

    always_comb
    begin
        case (item_reg.action)
            ACT_MOV: simple = b;
            ACT_OR:  simple = a | b;
            ACT_AND: simple = a & b;
            ACT_XOR: simple = a ^ b;
            ACT_NOT: simple = ~b;
            ACT_ADD: simple = a + b;
            ACT_SUB: simple = a - b;
            ACT_SHL: simple = (amt >= DATA_WIDTH) ? '0 : a << amt[CNT_W-1:0];
            ACT_SHR: simple = (amt >= DATA_WIDTH) ? '0 : a >> amt[CNT_W-1:0];
            ACT_NEG: simple = '0 - a;
            ACT_INC: simple = a + 1'b1;
            ACT_DEC: simple = a - 1'b1;
            default: simple = a;
        endcase
    end

    assign mul_acc = y_reg[0] ? acc_reg + x_reg : acc_reg;
    assign div_t   = {acc_reg, x_reg[DATA_WIDTH-1]};
    assign div_ge  = div_t >= {1'b0, y_reg};
    assign div_rem = div_ge ? DATA_WIDTH'(div_t - {1'b0, y_reg}) : div_t[DATA_WIDTH-1:0];
    assign div_q   = {x_reg[DATA_WIDTH-2:0], div_ge};

    assign slot_free = !out_valid_reg || !out_stall;
    assign ram_we    = state_reg == ST_WRITE && slot_free && wr_reg;

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        a_next     = a_reg;
        res_next   = res_reg;
        wr_next    = wr_reg;
        dz_next    = dz_reg;
        cmp_next   = cmp_reg;
        acc_next   = acc_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                a_next   = a;
                res_next = simple;
                wr_next  = item_reg.kind == KIND_SIMPLE || item_reg.kind == KIND_LONG;
                dz_next  = 1'b0;
                cmp_next = '0;
                cnt_next = '0;
                state_next = ST_WRITE;
                if (item_reg.kind == KIND_CMP)
                begin
                    cmp_next = (a > b ? FLAG_GREATER : '0) | (a < b ? FLAG_LESS : '0)
                             | (a == b ? FLAG_EQUAL : '0);
                end
                else if (item_reg.action == ACT_MUL)
                begin
                    acc_next   = '0;
                    x_next     = a;
                    y_next     = b;
                    state_next = ST_ITER;
                end
                else if (item_reg.action == ACT_DIV)
                begin
                    if (b == '0)
                    begin
                        res_next = ONES;
                        dz_next  = 1'b1;
                    end
                    else
                    begin
                        acc_next   = '0;
                        x_next     = a;
                        y_next     = b;
                        state_next = ST_ITER;
                    end
                end
            end
            ST_ITER:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (item_reg.action == ACT_MUL)
                begin
                    acc_next = mul_acc;
                    x_next   = x_reg << 1;
                    y_next   = y_reg >> 1;
                    res_next = mul_acc;
                end
                else
                begin
                    acc_next = div_rem;
                    x_next   = div_q;
                    res_next = div_q;
                end
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            vld_reg       <= '0;
            flags_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (ram_we)
            begin
                vld_reg[item_reg.dest_index] <= 1'b1;
            end
            if (state_reg == ST_WRITE && slot_free)
            begin
                flags_reg     <= flags_reg | cmp_reg;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            item_reg <= q_head;
        end
        a_reg   <= a_next;
        res_reg <= res_next;
        wr_reg  <= wr_next;
        dz_reg  <= dz_next;
        cmp_reg <= cmp_next;
        acc_reg <= acc_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        cnt_reg <= cnt_next;
        if (state_reg == ST_WRITE && slot_free)
        begin
            out_res_reg   <= wr_reg ? res_reg : a_reg;
            out_flags_reg <= flags_reg | cmp_reg;
            out_dz_reg    <= dz_reg;
        end
    end

    assign out_valid         = out_valid_reg;
    assign dest_result       = out_res_reg;
    assign compare_flags_out = out_flags_reg;
    assign divide_by_zero    = out_dz_reg;

`ifndef SYNTHESIS
    a_write_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> state_reg == ST_WRITE) else $error("register write outside write state");
    a_iter_exit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ITER |=> state_reg == ST_ITER || state_reg == ST_WRITE)
        else $error("iteration left early");
    a_flags_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (flags_reg & $past(flags_reg)) == $past(flags_reg)) else $error("flag cleared");
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> state_reg == ST_IDLE) else $error("pop while busy");
`endif

endmodule

@@ rtl/register_alu_execute_unit_top.sv @@
// top level of the register alu execute unit
// One alu instruction per item on a 16 x 64-bit register file; every item gives one result.
// The back end handles one item at a time. Simple operations, compares and division by zero
// go through queue push, queue pop with register file read, execute and the result register
// after the item is accepted, and hold the back end for its idle, read and write states.
// Multiply and divide run a shift-add or restoring unit one bit per cycle in an iteration
// state between execute and the result register, and hold the back end until the last bit. The
// front stage and two-entry queue keep accepting items while the back end is busy, until the
// queue is full. The result register lets the next item start while a finished result waits to be taken.
module register_alu_execute_unit_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [3:0]                     action,
    input  logic [rae_pkg::IDX_W-1:0]      dest_index,
    input  logic [rae_pkg::IDX_W-1:0]      src_index,
    input  logic                           use_immediate,
    input  logic [rae_pkg::DATA_WIDTH-1:0] immediate_value,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [rae_pkg::DATA_WIDTH-1:0] dest_result,
    output logic [rae_pkg::FLAG_W-1:0]     compare_flags_out,
    output logic                           divide_by_zero
);
    import rae_pkg::*;

    item_t push_item, head;
    logic  push, full, pop, empty;

    rae_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .action          (action),
        .dest_index      (dest_index),
        .src_index       (src_index),
        .use_immediate   (use_immediate),
        .immediate_value (immediate_value),
        .q_full          (full),
        .q_push          (push),
        .q_item          (push_item)
    );

    rae_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .empty     (empty),
        .head      (head)
    );

    rae_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .q_empty           (empty),
        .q_head            (head),
        .q_pop             (pop),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .dest_result       (dest_result),
        .compare_flags_out (compare_flags_out),
        .divide_by_zero    (divide_by_zero)
    );

endmodule
